>>> rtl/swo_pkg.sv
// Shared types and constants of the scanline waveform overlay unit.
package swo_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int PIX_W      = 16;
  localparam int DIM_W      = 11;
  localparam int PERIOD_W   = 16;
  localparam int SPACING_W  = 10;
  localparam int SCALE_W    = 16;
  localparam int COLOR_W    = 16;
  localparam int LADDR_W    = 20;
  localparam int CADDR_W    = 21;
  localparam int SIZE_W     = 2 * DIM_W;
  localparam int SIZE5_W    = SIZE_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = PIX_W;
  localparam int MOD_STEPS  = ROW_W;
  localparam int QUO_W      = PIX_W + 1;
  localparam int RDIFF_W    = QUO_W + 1;
  localparam int PROD_W     = RDIFF_W + DIM_W + 1;
  localparam int OFFS_W     = PROD_W + 1;

  // input tdata layout, lowest field first
  localparam int IN_COL_LSB  = 0;
  localparam int IN_ROW_LSB  = IN_COL_LSB + COL_W;
  localparam int IN_Y_LSB    = IN_ROW_LSB + ROW_W;
  localparam int IN_U_LSB    = IN_Y_LSB + PIX_W;
  localparam int IN_V_LSB    = IN_U_LSB + PIX_W;
  localparam int IN_FIELDS_W = IN_V_LSB + PIX_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_FIELDS_W = LADDR_W + 2 * CADDR_W + COLOR_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_PERIOD  = 3'd2,
    REG_SPACING = 3'd3,
    REG_SCALE   = 3'd4,
    REG_COLOR   = 3'd5
  } cfg_reg_t;

  localparam logic [DIM_W-1:0]     RST_WIDTH   = 11'd320;
  localparam logic [DIM_W-1:0]     RST_HEIGHT  = 11'd240;
  localparam logic [PERIOD_W-1:0]  RST_PERIOD  = 16'd1;
  localparam logic [SPACING_W-1:0] RST_SPACING = 10'd6;
  localparam logic [SCALE_W-1:0]   RST_SCALE   = 16'd50;
  localparam logic [COLOR_W-1:0]   RST_COLOR   = 16'hffff;

  typedef struct packed {
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    logic [SIZE_W-1:0]    size;
    logic [SIZE5_W-1:0]   size5;
    logic [PERIOD_W-1:0]  period;
    logic [SPACING_W-1:0] spacing;
    logic [SCALE_W-1:0]   scale;
    logic [COLOR_W-1:0]   color;
    logic                 busy;
  } swo_cfg_t;

  typedef struct packed {
    logic             keep;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] sum;
  } swo_front_t;

  typedef struct packed {
    logic                 keep;
    logic                 neg;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [SCALE_W-1:0]   rem;
    logic [PIX_W-1:0]     nq;
    logic [SPACING_W-1:0] mrem;
    logic [ROW_W-1:0]     mnum;
  } swo_div_t;

endpackage

>>> rtl/scanline_waveform_overlay_unit.sv
// Scanline waveform overlay: top level.
// Takes one pixel per clock when not held off or stalled by the output, and
// returns at most one trace write per pixel. The pipeline has one input
// stage, a 17-stage pipelined divider (a magnitude stage, then one quotient
// bit per stage for the 16-bit pixel sum, with the row-spacing remainder
// worked out alongside), and three address stages including the output
// register. Pixels with no write leave no output. Input is held off after
// reset and after each configuration write while the derived frame size settles.
module scanline_waveform_overlay_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // column[9:0], row[19:10], luma[35:20], chroma_u[51:36], chroma_v[67:52]
  input  logic [swo_pkg::IN_DATA_W-1:0]     in_tdata,
  // frame_start
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // luma_address[19:0], u_address[40:20], v_address[61:41], write_value[77:62]
  output logic [swo_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swo_pkg::CFG_DATA_W-1:0]    cfg_data
);

  swo_pkg::swo_cfg_t   cfg;
  swo_pkg::swo_front_t front_data;
  swo_pkg::swo_div_t   div_data;
  logic                front_valid, front_ready;
  logic                div_valid, div_ready;
  logic                drawing;

  swo_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swo_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_data     (in_tdata),
    .frame_start (in_tuser),
    .cfg         (cfg),
    .dn_valid    (front_valid),
    .dn_ready    (front_ready),
    .dn_data     (front_data),
    .drawing     (drawing)
  );

  swo_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .scale    (cfg.scale),
    .spacing  (cfg.spacing),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_data  (front_data),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_data  (div_data)
  );

  swo_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (div_valid),
    .up_ready  (div_ready),
    .up_data   (div_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input taken right after a configuration write");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_period_one_draws: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && (cfg.period <= swo_pkg::PERIOD_W'(1))
    |=> drawing)
    else $error("frame not drawn with grab period of one");

endmodule

>>> rtl/swo_cfg.sv
// Configuration registers and derived geometry of the overlay unit.
module swo_cfg #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swo_pkg::CFG_DATA_W-1:0]   cfg_data,
  output swo_pkg::swo_cfg_t                cfg
);

  localparam logic [1:0] SETTLE = 2'd3;

  logic [swo_pkg::DIM_W-1:0]     width_r, height_r, weff_r, heff_r;
  logic [swo_pkg::DIM_W-1:0]     weff_nxt, heff_nxt;
  logic [swo_pkg::PERIOD_W-1:0]  period_r;
  logic [swo_pkg::SPACING_W-1:0] spacing_r, spacing_eff_r;
  logic [swo_pkg::SCALE_W-1:0]   scale_r, scale_eff_r;
  logic [swo_pkg::COLOR_W-1:0]   color_r;
  logic [swo_pkg::SIZE_W-1:0]    size_r;
  logic [swo_pkg::SIZE5_W-1:0]   size5_r;
  logic [1:0]                    busy_r, busy_nxt;
  logic                          wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid;

  assign weff_nxt = (32'(width_r) > MAX_WIDTH) ? swo_pkg::DIM_W'(MAX_WIDTH) : width_r;
  assign heff_nxt = (32'(height_r) > MAX_HEIGHT) ? swo_pkg::DIM_W'(MAX_HEIGHT) : height_r;

  always_comb begin
    busy_nxt = busy_r;
    if (wr) begin
      busy_nxt = SETTLE;
    end else if (busy_r != 2'd0) begin
      busy_nxt = busy_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= swo_pkg::RST_WIDTH;
      height_r  <= swo_pkg::RST_HEIGHT;
      period_r  <= swo_pkg::RST_PERIOD;
      spacing_r <= swo_pkg::RST_SPACING;
      scale_r   <= swo_pkg::RST_SCALE;
      color_r   <= swo_pkg::RST_COLOR;
      busy_r    <= SETTLE;
    end else begin
      busy_r <= busy_nxt;
      if (wr) begin
        unique case (cfg_index)
          swo_pkg::REG_WIDTH:   width_r   <= cfg_data[swo_pkg::DIM_W-1:0];
          swo_pkg::REG_HEIGHT:  height_r  <= cfg_data[swo_pkg::DIM_W-1:0];
          swo_pkg::REG_PERIOD:  period_r  <= cfg_data[swo_pkg::PERIOD_W-1:0];
          swo_pkg::REG_SPACING: spacing_r <= cfg_data[swo_pkg::SPACING_W-1:0];
          swo_pkg::REG_SCALE:   scale_r   <= cfg_data[swo_pkg::SCALE_W-1:0];
          swo_pkg::REG_COLOR:   color_r   <= cfg_data[swo_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // derived values settle while busy counts down from SETTLE; input is held off meanwhile
  always_ff @(posedge clk) begin
    weff_r        <= weff_nxt;
    heff_r        <= heff_nxt;
    spacing_eff_r <= (spacing_r == '0) ? swo_pkg::SPACING_W'(1) : spacing_r;
    scale_eff_r   <= (scale_r == '0) ? swo_pkg::SCALE_W'(1) : scale_r;
    size_r        <= swo_pkg::SIZE_W'(weff_r) * swo_pkg::SIZE_W'(heff_r);
    size5_r       <= {1'b0, size_r} + {3'b0, size_r[swo_pkg::SIZE_W-1:2]};
  end

  assign cfg.width   = weff_r;
  assign cfg.height  = heff_r;
  assign cfg.size    = size_r;
  assign cfg.size5   = size5_r;
  assign cfg.period  = period_r;
  assign cfg.spacing = spacing_eff_r;
  assign cfg.scale   = scale_eff_r;
  assign cfg.color   = color_r;
  assign cfg.busy    = (busy_r != 2'd0);

endmodule

>>> rtl/swo_front.sv
// Input stage: grab counter, frame bounds check and pixel sum.
module swo_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [swo_pkg::IN_DATA_W-1:0]    in_data,
  input  logic                             frame_start,
  input  swo_pkg::swo_cfg_t                cfg,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output swo_pkg::swo_front_t              dn_data,
  output logic                             drawing
);

  logic                            v_r, rdy, acc;
  logic                            drawing_r, drawing_nxt;
  logic [swo_pkg::PERIOD_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  logic [swo_pkg::COL_W-1:0]       col;
  logic [swo_pkg::ROW_W-1:0]       row;
  logic [swo_pkg::PIX_W-1:0]       y, u, v;
  swo_pkg::swo_front_t             d_r, d_nxt;

  assign col = in_data[swo_pkg::IN_COL_LSB +: swo_pkg::COL_W];
  assign row = in_data[swo_pkg::IN_ROW_LSB +: swo_pkg::ROW_W];
  assign y   = in_data[swo_pkg::IN_Y_LSB +: swo_pkg::PIX_W];
  assign u   = in_data[swo_pkg::IN_U_LSB +: swo_pkg::PIX_W];
  assign v   = in_data[swo_pkg::IN_V_LSB +: swo_pkg::PIX_W];

  assign rdy      = !v_r || dn_ready;
  assign in_ready = rdy && !cfg.busy;
  assign acc      = in_valid && in_ready;
  assign cnt_inc  = cnt_r + swo_pkg::PERIOD_W'(1);

  always_comb begin
    cnt_nxt     = cnt_r;
    drawing_nxt = drawing_r;
    if (frame_start) begin
      if (cnt_inc >= cfg.period) begin
        cnt_nxt     = '0;
        drawing_nxt = 1'b1;
      end else begin
        cnt_nxt     = cnt_inc;
        drawing_nxt = 1'b0;
      end
    end
    d_nxt.keep = drawing_nxt && ({1'b0, col} < cfg.width) && ({1'b0, row} < cfg.height);
    d_nxt.col  = col;
    d_nxt.row  = row;
    d_nxt.sum  = y + u + v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= 1'b0;
      cnt_r     <= '0;
      drawing_r <= 1'b0;
    end else begin
      if (rdy) begin
        v_r <= acc;
      end
      if (acc) begin
        cnt_r     <= cnt_nxt;
        drawing_r <= drawing_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;
  assign drawing  = drawing_r;

endmodule

>>> rtl/swo_div_pipe.sv
// Pipelined restoring divider: sum / scale and row % spacing, one bit per stage.
module swo_div_pipe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [swo_pkg::SCALE_W-1:0]         scale,
  input  logic [swo_pkg::SPACING_W-1:0]       spacing,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  swo_pkg::swo_front_t                 up_data,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output swo_pkg::swo_div_t                   dn_data
);

  localparam int NS = swo_pkg::DIV_STEPS + 1;

  logic              v_r   [NS];
  logic              rdy   [NS+1];
  swo_pkg::swo_div_t st_r  [NS];
  swo_pkg::swo_div_t st_nxt[NS];

  assign rdy[NS]  = dn_ready;
  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];
  assign dn_data  = st_r[NS-1];

  // stage 0 takes the magnitude of the sum
  always_comb begin
    st_nxt[0].keep = up_data.keep;
    st_nxt[0].neg  = up_data.sum[swo_pkg::PIX_W-1];
    st_nxt[0].col  = up_data.col;
    st_nxt[0].row  = up_data.row;
    st_nxt[0].rem  = '0;
    st_nxt[0].nq   = up_data.sum[swo_pkg::PIX_W-1] ?
                     (~up_data.sum + swo_pkg::PIX_W'(1)) : up_data.sum;
    st_nxt[0].mrem = '0;
    st_nxt[0].mnum = up_data.row;
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [swo_pkg::SCALE_W:0]   t;
    logic [swo_pkg::SPACING_W:0] tm;
    logic                        ge, gm;

    always_comb begin
      st_nxt[k] = st_r[k-1];
      t  = {st_r[k-1].rem, st_r[k-1].nq[swo_pkg::PIX_W-1]};
      ge = (t >= {1'b0, scale});
      st_nxt[k].rem = ge ? swo_pkg::SCALE_W'(t - {1'b0, scale}) : t[swo_pkg::SCALE_W-1:0];
      st_nxt[k].nq  = {st_r[k-1].nq[swo_pkg::PIX_W-2:0], ge};
      tm = {st_r[k-1].mrem, st_r[k-1].mnum[swo_pkg::ROW_W-1]};
      gm = (tm >= {1'b0, spacing});
      if (k <= swo_pkg::MOD_STEPS) begin
        st_nxt[k].mrem = gm ? swo_pkg::SPACING_W'(tm - {1'b0, spacing})
                            : tm[swo_pkg::SPACING_W-1:0];
        st_nxt[k].mnum = {st_r[k-1].mnum[swo_pkg::ROW_W-2:0], 1'b0};
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic vin;

    assign rdy[k] = !v_r[k] || rdy[k+1];
    if (k == 0) begin : g_first
      assign vin = up_valid;
    end else begin : g_next
      assign vin = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

endmodule

>>> rtl/swo_addr.sv
// Address stages: row shift, multiply by width, range check and plane addresses.
module swo_addr (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swo_pkg::swo_cfg_t                  cfg,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  swo_pkg::swo_div_t                  up_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [swo_pkg::OUT_DATA_W-1:0]     out_data
);

  logic                              v1_r, v2_r, ov_r;
  logic                              rdy1, rdy2, rdy3;
  logic                              keep1_r, keep2_r, keep1_nxt, ok;
  logic [swo_pkg::COL_W-1:0]         col1_r, col2_r;
  logic [swo_pkg::QUO_W-1:0]         qmag, qval;
  logic [swo_pkg::RDIFF_W-1:0]       rdiff_r, rdiff_nxt;
  logic signed [swo_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [swo_pkg::OFFS_W-1:0]        offs;
  logic [swo_pkg::LADDR_W-1:0]       laddr_r;
  logic [swo_pkg::CADDR_W-1:0]       uaddr_r, vaddr_r, uaddr_nxt, vaddr_nxt;
  logic [swo_pkg::COLOR_W-1:0]       color_r;

  assign rdy3     = !ov_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  assign qmag      = {1'b0, up_data.nq};
  assign qval      = up_data.neg ? (~qmag + swo_pkg::QUO_W'(1)) : qmag;
  assign rdiff_nxt = {{(swo_pkg::RDIFF_W-swo_pkg::ROW_W){1'b0}}, up_data.row}
                   - {qval[swo_pkg::QUO_W-1], qval};
  assign keep1_nxt = up_data.keep && (up_data.mrem == '0);

  assign prod_nxt = swo_pkg::PROD_W'($signed(rdiff_r))
                  * swo_pkg::PROD_W'($signed({1'b0, cfg.width}));

  assign offs = {prod_r[swo_pkg::PROD_W-1], prod_r}
              + {{(swo_pkg::OFFS_W-swo_pkg::COL_W){1'b0}}, col2_r};
  assign ok   = keep2_r && !offs[swo_pkg::OFFS_W-1]
              && (offs[swo_pkg::PROD_W-1:0]
                  < {{(swo_pkg::PROD_W-swo_pkg::SIZE_W){1'b0}}, cfg.size});
  assign uaddr_nxt = swo_pkg::CADDR_W'(
      {{(swo_pkg::PROD_W-swo_pkg::SIZE_W){1'b0}}, cfg.size}
    + {2'b0, offs[swo_pkg::PROD_W-1:2]});
  assign vaddr_nxt = swo_pkg::CADDR_W'(
      {{(swo_pkg::PROD_W-swo_pkg::SIZE5_W){1'b0}}, cfg.size5}
    + {2'b0, offs[swo_pkg::PROD_W-1:2]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        ov_r <= v2_r && ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      keep1_r <= keep1_nxt;
      col1_r  <= up_data.col;
      rdiff_r <= rdiff_nxt;
    end
    if (rdy2) begin
      keep2_r <= keep1_r;
      col2_r  <= col1_r;
      prod_r  <= prod_nxt;
    end
    if (rdy3) begin
      laddr_r <= offs[swo_pkg::LADDR_W-1:0];
      uaddr_r <= uaddr_nxt;
      vaddr_r <= vaddr_nxt;
      color_r <= cfg.color;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = {{(swo_pkg::OUT_DATA_W-swo_pkg::OUT_FIELDS_W){1'b0}},
                      color_r, vaddr_r, uaddr_r, laddr_r};

endmodule
